>>> src/p2i_pkg.sv
`default_nettype none
package p2i_pkg;

  typedef enum logic [2:0] {
    ENC_INT16   = 3'd0,
    ENC_UINT8   = 3'd1,
    ENC_FLOAT32 = 3'd2,
    ENC_PACK24  = 3'd3,
    ENC_INT32   = 3'd4
  } enc_t;

  // Bytes per sample for an encoding code; unused codes act as int16.
  function automatic logic [2:0] bytes_per_sample(input logic [2:0] enc);
    logic [2:0] n;
    case (enc)
      ENC_UINT8:   n = 3'd1;
      ENC_FLOAT32: n = 3'd4;
      ENC_PACK24:  n = 3'd3;
      ENC_INT32:   n = 3'd4;
      default:     n = 3'd2;
    endcase
    return n;
  endfunction

  // A completed 32-bit word with its encoding.
  typedef struct packed {
    logic [2:0]  enc;
    logic [31:0] word;
  } word_t;

endpackage
`default_nettype wire

>>> src/p2i_if.sv
`default_nettype none
interface byte_if (input wire logic clk);
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       buffer_end;
  modport source (output valid, data_byte, buffer_end, input ready);
  modport sink (input valid, data_byte, buffer_end, output ready);
endinterface

interface sample_if (input wire logic clk);
  logic               valid;
  logic               ready;
  logic signed [15:0] sample;
  modport source (output valid, sample, input ready);
  modport sink (input valid, sample, output ready);
endinterface
`default_nettype wire

>>> src/pcm_to_int16_converter.sv
// The item for the accepted byte completing a sample is on the output register
// in the next cycle.
// Throughput: one byte per cycle; the gather register and a one-deep output
// register whose ready passes through let bytes flow while the sink is ready.
// Reset: synchronous; clears encoding to int16, the gather state and the output valid flag.
`default_nettype none
module pcm_to_int16_converter import p2i_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  cfg_we,
  input  wire logic [2:0] cfg_wdata,
  byte_if.sink       in_ch,
  sample_if.source   out_ch
);
  logic [2:0]  encoding;
  logic [23:0] byte_gather;
  logic [1:0]  byte_count;
  logic        out_valid;
  logic signed [15:0] out_sample;
  logic [31:0] word;
  logic        done, take;
  logic signed [15:0] fres, res;

  assign in_ch.ready   = !out_valid || out_ch.ready;
  assign take          = in_ch.valid && in_ch.ready;
  assign out_ch.valid  = out_valid;
  assign out_ch.sample = out_sample;

  // Merge the new byte into the gathered bytes.
  always_comb begin
    word = {8'd0, byte_gather} | ({24'd0, in_ch.data_byte} << {byte_count, 3'b000});
    done = ({1'b0, byte_count} + 3'd1) >= bytes_per_sample(encoding);
  end

  p2i_float_conv u_fc (.bits(word), .result(fres));

  // Select the result by encoding.
  always_comb begin
    case (encoding)
      ENC_UINT8:   res = $signed({in_ch.data_byte ^ 8'h80, 8'd0});
      ENC_FLOAT32: res = fres;
      ENC_PACK24:  res = $signed(word[23:8]);
      ENC_INT32:   res = $signed(word[31:16]);
      default:     res = $signed(word[15:0]);
    endcase
  end

  // Gather state, configuration and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      encoding <= ENC_INT16; byte_gather <= '0; byte_count <= '0; out_valid <= 1'b0;
    end else begin
      if (take && done && !cfg_we) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_we) begin
        encoding <= cfg_wdata; byte_gather <= '0; byte_count <= '0;
      end else if (take) begin
        if (done || in_ch.buffer_end) begin
          byte_gather <= '0; byte_count <= '0;
        end else begin
          byte_gather <= word[23:0]; byte_count <= byte_count + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && done && !cfg_we) out_sample <= res;
  end

  // A stalled item holds until taken.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ch.ready |=> out_valid && $stable(out_sample))
    else $error("output item dropped under stall");
  // A byte that does not complete a sample produces no item.
  a_noitem: assert property (@(posedge clk) disable iff (rst)
    take && !done && !cfg_we && (!out_valid || out_ch.ready) |=> !out_valid)
    else $error("item without completed sample");
  // Count never reaches the byte count of the encoding.
  a_cnt: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, byte_count} < bytes_per_sample(encoding)))
    else $error("byte count overflow");
endmodule
`default_nettype wire

>>> src/p2i_float_conv.sv
`default_nettype none
module p2i_float_conv import p2i_pkg::*; (
  input  wire logic [31:0]        bits,
  output logic signed [15:0]      result
);
  logic        sgn;
  logic [7:0]  ex;
  logic [23:0] mant;
  logic [39:0] sh;
  logic [16:0] mag;
  logic [3:0]  amt;

  // Value times 32768 is mant * 2^(ex-135). Exponents 111 to 126 give a
  // magnitude from one half up to just below 32768; sh holds it with 24
  // fraction bits, so sh[39:24] is the integer part and sh[23] the half bit.
  // Adding one half in single precision turns the largest value just below
  // one half into exactly one, so that single pattern gives magnitude one.
  always_comb begin
    sgn  = bits[31];
    ex   = bits[30:23];
    mant = {(ex != 8'd0), bits[22:0]};
    sh   = '0;
    amt  = '0;
    mag  = '0;
    if (ex == 8'd110 && bits[22:0] == 23'h7FFFFF) begin
      mag = 17'd1;
    end else if (ex >= 8'd111 && ex <= 8'd126) begin
      amt = 4'(ex - 8'd111);
      sh  = {16'd0, mant} << amt;
      mag = {1'b0, sh[39:24]} + {16'd0, sh[23]};
    end else if (ex > 8'd126) begin
      mag = 17'h10000;
    end
    if (ex == 8'hFF && bits[22:0] != 23'd0) begin
      result = '0;
    end else if (sgn) begin
      result = (mag >= 17'h08000) ? $signed(16'h8000) : -$signed(mag[15:0]);
    end else begin
      result = (mag >= 17'h07FFF) ? 16'sd32767 : $signed(mag[15:0]);
    end
  end
endmodule
`default_nettype wire

>>> sim/pcm_sample_monitor.sv
`default_nettype none
module pcm_sample_monitor import p2i_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  cfg_we,
  input  wire logic [2:0] cfg_wdata,
  byte_if            bytes_in,
  sample_if          samples_out,
  output int         fail_count,
  output int         pending_count,
  output int         sample_count
);

  logic [2:0]  enc_now;
  logic [23:0] gathered;
  int          gathered_n;
  logic [15:0] expected_samples[$];

  // Number of bytes that make one sample; spare codes act as int16.
  function automatic int sample_bytes(logic [2:0] enc);
    case (enc)
      ENC_UINT8:   return 1;
      ENC_FLOAT32: return 4;
      ENC_PACK24:  return 3;
      ENC_INT32:   return 4;
      default:     return 2;
    endcase
  endfunction

  // Scales a float32 by 32768, clamps and rounds half away from zero. The
  // half is added in single precision, so the sum is rounded to 24 bits.
  function automatic logic [15:0] float_to_pcm(logic [31:0] w);
    real    mag;
    real    total;
    real    ulp;
    real    q;
    int     ex;
    int     e;
    longint qi;
    int     v;
    ex = w[30:23];
    if (ex == 255 && w[22:0] != 0) return 16'd0;
    if (ex == 255) mag = 1.0e10;
    else if (ex == 0) mag = w[22:0] * (2.0 ** (-149));
    else mag = (8388608.0 + w[22:0]) * (2.0 ** (ex - 150));
    mag = mag * 32768.0;
    if (!w[31] && mag > 32767.0) mag = 32767.0;
    if (w[31] && mag > 32768.0) mag = 32768.0;
    total = mag + 0.5;
    e = 0;
    while (2.0 ** (e + 1) <= total) e++;
    while (2.0 ** e > total) e--;
    ulp = 2.0 ** (e - 23);
    q = total / ulp;
    qi = $rtoi(q);
    if (q - qi > 0.5 || (q - qi == 0.5 && qi[0])) qi++;
    v = $rtoi(qi * ulp);
    if (w[31]) v = -v;
    return v[15:0];
  endfunction

  assign pending_count = expected_samples.size();

  always @(posedge clk) begin
    logic [31:0] word;
    logic [15:0] got;
    logic [15:0] pred;
    if (rst) begin
      enc_now    <= ENC_INT16;
      gathered   <= '0;
      gathered_n <= 0;
      fail_count <= 0;
      sample_count <= 0;
      expected_samples.delete();
    end else begin
      // Compare each delivered sample with the oldest prediction.
      if (samples_out.valid && samples_out.ready) begin
        sample_count <= sample_count + 1;
        if (expected_samples.size() == 0) begin
          $error("unexpected sample: actual %0d", $signed(samples_out.sample));
          fail_count <= fail_count + 1;
        end else begin
          got = expected_samples.pop_front();
          if (got !== samples_out.sample) begin
            $error("sample mismatch: expected %0d actual %0d",
                   $signed(got), $signed(samples_out.sample));
            fail_count <= fail_count + 1;
          end
        end
      end
      // A register write drops any partial sample.
      if (cfg_we) begin
        enc_now    <= cfg_wdata;
        gathered   <= '0;
        gathered_n <= 0;
      end else if (bytes_in.valid && bytes_in.ready) begin
        word = {8'd0, gathered} | (32'(bytes_in.data_byte) << (8 * gathered_n));
        if (gathered_n + 1 >= sample_bytes(enc_now)) begin
          case (enc_now)
            ENC_UINT8:   pred = {bytes_in.data_byte ^ 8'h80, 8'h00};
            ENC_FLOAT32: pred = float_to_pcm(word);
            ENC_PACK24:  pred = word[23:8];
            ENC_INT32:   pred = word[31:16];
            default:     pred = word[15:0];
          endcase
          expected_samples.insert(expected_samples.size(), pred);
        end
        // A completed sample or a buffer end starts a fresh sample.
        if (gathered_n + 1 >= sample_bytes(enc_now) || bytes_in.buffer_end) begin
          gathered   <= '0;
          gathered_n <= 0;
        end else begin
          gathered   <= word[23:0];
          gathered_n <= gathered_n + 1;
        end
      end
    end
  end

  final begin
    if (expected_samples.size() != 0)
      $error("%0d predicted samples never delivered", expected_samples.size());
  end

endmodule
`default_nettype wire

>>> sim/tb_pcm_to_int16_converter.sv
`default_nettype none
module tb_pcm_to_int16_converter;
  import p2i_pkg::*;

  localparam logic [2:0] ENC_SPARE_TOP = 3'd7;

  logic       clk;
  logic       rst;
  logic       cfg_we;
  logic [2:0] cfg_wdata;
  int         fail_count;
  int         pending_count;
  int         sample_count;
  int         bytes_sent;
  bit         calm;
  bit         hold_sink;
  bit         leftover_fail;

  byte_if   in_ch (clk);
  sample_if out_ch (clk);

  pcm_to_int16_converter i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  pcm_sample_monitor i_monitor (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .bytes_in      (in_ch),
    .samples_out   (out_ch),
    .fail_count    (fail_count),
    .pending_count (pending_count),
    .sample_count  (sample_count)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Sample sink: random stall bursts, one long hold on request.
  initial begin
    int left;
    bit rdy;
    out_ch.ready = 1'b0;
    left = 0;
    rdy  = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_sink) begin
        out_ch.ready <= 1'b0;
        repeat (300) @(negedge clk);
        hold_sink = 1'b0;
      end
      if (calm) begin
        rdy = 1'b1;
      end else if (left == 0) begin
        rdy  = ($urandom_range(0, 2) != 0);
        left = $urandom_range(1, 14);
      end else begin
        left--;
      end
      out_ch.ready <= rdy;
    end
  end

  // Offers one byte and waits until it is accepted.
  task automatic send_byte(logic [7:0] b, logic last);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.data_byte  <= b;
    in_ch.buffer_end <= last;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    bytes_sent++;
  endtask

  // Sends a sample of n bytes, least significant byte first.
  task automatic send_word(logic [31:0] w, int n, logic last);
    for (int k = 0; k < n; k++)
      send_byte(w[8*k +: 8], last && k == n - 1);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_encoding(logic [2:0] enc);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= enc;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  function automatic int width_of(logic [2:0] enc);
    case (enc)
      ENC_UINT8:   return 1;
      ENC_FLOAT32: return 4;
      ENC_PACK24:  return 3;
      ENC_INT32:   return 4;
      default:     return 2;
    endcase
  endfunction

  // Float payloads: half values near the int16 range, the rest raw, zero or special.
  function automatic logic [31:0] float_payload();
    case ($urandom_range(0, 5))
      0:       return $urandom();
      1:       return {1'($urandom()), 8'hff, 23'($urandom_range(0, 1) * $urandom())};
      2:       return {1'($urandom()), 31'd0};
      default: return {1'($urandom()), 8'($urandom_range(100, 128)), 23'($urandom())};
    endcase
  endfunction

  initial begin
    logic [2:0] enc;
    int n;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = ENC_INT16;
    in_ch.valid = 1'b0;
    in_ch.data_byte = 8'd0;
    in_ch.buffer_end = 1'b0;
    calm = 1'b0;
    hold_sink = 1'b0;
    bytes_sent = 0;
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: extremes for int16, uint8 and float32, partial sample cut by a buffer end.
    send_word(32'h8000, 2, 1'b0);
    send_word(32'h7fff, 2, 1'b1);
    set_encoding(ENC_UINT8);
    send_byte(8'h00, 1'b0);
    send_byte(8'hff, 1'b1);
    set_encoding(ENC_PACK24);
    send_word(32'h0000ff, 2, 1'b1);
    send_word(32'h80ff01, 3, 1'b0);
    set_encoding(ENC_FLOAT32);
    send_word(32'h3f000000, 4, 1'b0);
    send_word(32'h7fc00000, 4, 1'b0);
    send_word(32'hff800000, 4, 1'b0);
    send_word(32'h3f800000, 4, 1'b0);
    // Just below one half after scaling, on both signs.
    send_word(32'h377fffff, 4, 1'b0);
    send_word(32'hb77fffff, 4, 1'b0);
    set_encoding(ENC_INT32);
    send_word(32'hfedcba98, 4, 1'b0);
    send_byte(8'h55, 1'b0);
    set_encoding(ENC_SPARE_TOP);
    send_word(32'h1234, 2, 1'b0);

    // Random phases, each with its own encoding.
    for (int ph = 0; ph < 16; ph++) begin
      enc = (ph == 0) ? ENC_INT32 : (ph == 1) ? ENC_SPARE_TOP : 3'($urandom_range(0, 7));
      if (ph == 3) enc = ENC_FLOAT32;
      set_encoding(enc);
      if (ph == 13) calm = 1'b1;
      if (ph == 5) hold_sink = 1'b1;
      n = 0;
      while (n < 88) begin
        if ($urandom_range(0, 15) == 0) begin
          send_byte($urandom(), 1'b1);
          n++;
        end else begin
          send_word(enc == ENC_FLOAT32 ? float_payload() : $urandom(), width_of(enc),
                    $urandom_range(0, 7) == 0);
          n += width_of(enc);
        end
      end
      if (ph == 8) drain();
    end

    drain();
    repeat (20) @(negedge clk);
    leftover_fail = (pending_count != 0);
    $display("Sent %0d bytes over all encodings and %0d samples came back checked.",
             bytes_sent, sample_count);
    if (fail_count == 0 && !leftover_fail) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
`default_nettype wire

>>> filelist.f
src/p2i_pkg.sv
src/p2i_if.sv
src/p2i_float_conv.sv
src/pcm_to_int16_converter.sv
sim/pcm_sample_monitor.sv
sim/tb_pcm_to_int16_converter.sv
